/* hdl/pfrd_pkg.sv */
// Package for the prefix-function repeat detector.
// Holds the default sizes and the fixed port widths; no dependencies.
package pfrd_pkg;

  // Widths of the fixed port fields.
  localparam int SYM_IN_W = 8;
  localparam int OUT_W    = 13;

  // Defaults for the top-level parameters.
  localparam int MAX_LEN_DEF     = 4096;
  localparam int SYMBOL_BITS_DEF = 8;

endpackage

/* hdl/prefix_function_repeat_detect.sv */
// Top level of the prefix-function repeat detector.
// Depends on pfrd_pkg and pfrd_ram.
//
// Takes one symbol per input transfer and builds the KMP border table in two
// synchronous RAMs (symbols and border lengths). A symbol follows failure
// links step by step: each step reads the symbol store and the border table
// in parallel and the compare runs on the registered read data. The final
// symbol of a string adds a restoring remainder unit, one bit a cycle. The
// result sits in an output register; the next string may start while it
// waits to be taken. Symbols past MAX_LEN are dropped and raise too_long.
module prefix_function_repeat_detect #(
  parameter int MAX_LEN     = pfrd_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = pfrd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfrd_pkg::SYM_IN_W-1:0] in_symbol,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_repeated,
  output logic [pfrd_pkg::OUT_W-1:0]   out_period,
  output logic [pfrd_pkg::OUT_W-1:0]   out_string_length,
  output logic                         out_too_long
);

  localparam int AW     = $clog2(MAX_LEN);
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int DIV_CW = $clog2(CW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          k_r, k_nxt;
  logic [AW-1:0]          match_r, match_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CW-1:0]          period_r, period_nxt;
  logic [CW-1:0]          len_r, len_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [CW-1:0]          dvd_r, dvd_nxt;
  logic [DIV_CW-1:0]      div_cnt_r, div_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_rep_r, out_rep_nxt;
  logic [pfrd_pkg::OUT_W-1:0] out_period_r, out_period_nxt;
  logic [pfrd_pkg::OUT_W-1:0] out_len_r, out_len_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  // RAM ports
  logic [SYMBOL_BITS-1:0] sym_rdata;
  logic [AW-1:0]          bor_rdata;
  logic [AW-1:0]          rd_k;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          k_new;

  // Result setup
  logic                   res_start;
  logic [CW-1:0]          res_len;
  logic [AW-1:0]          res_match;
  logic [CW:0]            div_trial;

  logic in_xfer;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  pfrd_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_sym_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (sym_r),
    .raddr (rd_k),
    .rdata (sym_rdata)
  );

  pfrd_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_LEN)
  ) u_bor_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (k_new),
    .raddr (rd_k - AW'(1)),
    .rdata (bor_rdata)
  );

  assign wr_addr   = count_r[AW-1:0];
  assign div_trial = {rem_r, dvd_r[CW-1]};

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    k_nxt          = k_r;
    match_nxt      = match_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    period_nxt     = period_r;
    len_nxt        = len_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_rep_nxt    = out_rep_r;
    out_period_nxt = out_period_r;
    out_len_nxt    = out_len_r;
    out_ovf_nxt    = out_ovf_r;
    rd_k           = match_r;
    wr_en          = 1'b0;
    k_new          = '0;
    res_start      = 1'b0;
    res_len        = count_r;
    res_match      = match_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          sym_nxt  = SYMBOL_BITS'(in_symbol);
          last_nxt = in_last;
          k_nxt    = match_r;
          if (count_r == CW'(MAX_LEN)) begin
            // Overlong string: drop the symbol, table untouched.
            ovf_nxt = 1'b1;
            if (in_last) begin
              res_start = 1'b1;
            end
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // Read data belongs to k_r: symbol at k, border at k-1.
        rd_k = bor_rdata;
        if (count_r == '0) begin
          wr_en = 1'b1;
          k_new = '0;
        end else if (sym_rdata == sym_r) begin
          wr_en = 1'b1;
          k_new = k_r + AW'(1);
        end else if (k_r == '0) begin
          wr_en = 1'b1;
          k_new = '0;
        end else begin
          k_nxt = bor_rdata;
        end
        if (wr_en) begin
          match_nxt = k_new;
          count_nxt = count_r + CW'(1);
          res_len   = count_r + CW'(1);
          res_match = k_new;
          if (last_r) begin
            res_start = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DIV: begin
        // Restoring remainder of len / period, one dividend bit a cycle.
        if (div_trial >= {1'b0, period_r}) begin
          rem_nxt = CW'(div_trial - {1'b0, period_r});
        end else begin
          rem_nxt = div_trial[CW-1:0];
        end
        dvd_nxt     = dvd_r << 1;
        div_cnt_nxt = div_cnt_r - DIV_CW'(1);
        if (div_cnt_r == DIV_CW'(1)) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_rep_nxt    = (period_r != '0) && (period_r != len_r) && (rem_r == '0);
          out_period_nxt = pfrd_pkg::OUT_W'(period_r);
          out_len_nxt    = pfrd_pkg::OUT_W'(len_r);
          out_ovf_nxt    = ovf_r;
          match_nxt      = '0;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_start) begin
      len_nxt     = res_len;
      period_nxt  = (CW'(res_match) < res_len) ? res_len - CW'(res_match) : res_len;
      rem_nxt     = '0;
      dvd_nxt     = res_len;
      div_cnt_nxt = DIV_CW'(CW);
      state_nxt   = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      match_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_r     <= match_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    k_r          <= k_nxt;
    period_r     <= period_nxt;
    len_r        <= len_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_rep_r    <= out_rep_nxt;
    out_period_r <= out_period_nxt;
    out_len_r    <= out_len_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_is_repeated   = out_rep_r;
  assign out_period        = out_period_r;
  assign out_string_length = out_len_r;
  assign out_too_long      = out_ovf_r;

  // The border of a nonempty prefix is always shorter than the prefix.
  a_border_short: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> CW'(match_r) < count_r)
    else $error("match length not below character count");

  a_border_empty: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> match_r == '0)
    else $error("nonzero match length on an empty string");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("character count beyond MAX_LEN");

  // Symbols are only dropped once the table is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CW'(MAX_LEN))
    else $error("overflow flag set before table is full");

  // A failure-link walk never reaches the position being written.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && count_r != '0) |-> CW'(k_r) < count_r)
    else $error("walk index not below write position");

endmodule

/* hdl/pfrd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the symbol store and the border table.
module pfrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
